>>> hdl/ght_pkg.sv
// shared types and constants for the generational handle table
package ght_pkg;

   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_DESTROY = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_STALE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_READ   = 10'b0000000010,
      S_DECIDE = 10'b0000000100,
      S_MOVE   = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_SCHK   = 10'b0000100000,
      S_FIX    = 10'b0001000000,
      S_KILL   = 10'b0010000000,
      S_POP    = 10'b0100000000,
      S_RESP   = 10'b1000000000
   } state_type;

endpackage

>>> hdl/ght_ram.sv
// generic single port write, single port read ram with registered read
module ght_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hdl/generational_handle_table.sv
// top level of the generational handle table
//
// usage
//   req_ channel carries one item: func, handle index and generation, payload
//   rsp_ channel returns exactly one item per request item, in order
//   add returns a new handle (index, generation); destroy retires a handle;
//   lookup returns the payload of a live handle; stale handles give status 1,
//   a full table gives status 2, and nothing changes in either case
// sequencing
//   lookup, unused codes and rejected destroys pass through S_READ, S_DECIDE
//   and S_RESP; add runs S_POP between S_DECIDE and S_RESP
//   destroy moves the last dense entry into the hole in S_MOVE, then walks the
//   slot map for the slot owning it, each slot examined going through S_SCAN
//   and S_SCHK; S_FIX retargets that slot on a match, then S_KILL and S_RESP
//   one item is in flight at a time; the next item is taken the cycle after
//   the result leaves
// reset
//   synchronous, active high; counters, live bits and state machine clear at
//   once; the generation memory is not cleared, a fresh slot has its
//   generation written to zero on first issue
// stalls
//   the result waits in an output register while rsp_ready is low; the
//   block takes no new item until the result has gone
module generational_handle_table #(
   parameter int CAPACITY      = 256,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_handle_index,
   input  logic [31:0] req_handle_generation,
   input  logic [31:0] req_payload_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_index,
   output logic [31:0] rsp_out_generation,
   output logic [31:0] rsp_payload_out,
   output logic [1:0]  rsp_status
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // state machine and request registers
   ght_pkg::state_type state_ff, state_in;
   logic [1:0]  func_ff;
   logic [AW-1:0] idx_ff;
   logic        idx_big_ff;
   logic [31:0] gen_ff;
   logic [PAYLOAD_WIDTH-1:0] pay_ff;

   // counters
   logic [CW-1:0] free_count_ff, slots_issued_ff, dense_count_ff;

   // live bits per slot, in flip-flops
   logic [CAPACITY-1:0] live_ff;

   // working registers
   logic [AW-1:0] slot_ff;   // slot chosen by add
   logic          fresh_ff;  // slot came from the fresh pool
   logic [AW-1:0] hole_ff;   // dense position of the destroyed entry
   logic [AW-1:0] scan_ff;   // scan slot index
   logic [CW-1:0] scan_cnt_ff;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_idx_ff;
   logic [31:0] rsp_gen_ff, rsp_pay_ff;
   logic [1:0]  rsp_st_ff;

   // memory ports
   logic                     dn_we;
   logic [AW-1:0]            dn_wa, dn_ra;
   logic [PAYLOAD_WIDTH-1:0] dn_wd, dn_rd;
   logic                     sd_we;
   logic [AW-1:0]            sd_wa, sd_ra, sd_wd, sd_rd;
   logic                     gn_we;
   logic [AW-1:0]            gn_wa, gn_ra;
   logic [31:0]              gn_wd, gn_rd;
   logic                     fs_we;
   logic [AW-1:0]            fs_wa, fs_ra, fs_wd, fs_rd;

   ght_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(CAPACITY)) u_dense (
      .clock(clock), .wr_en(dn_we), .wr_addr(dn_wa), .wr_data(dn_wd),
      .rd_addr(dn_ra), .rd_data(dn_rd));
   ght_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_map (
      .clock(clock), .wr_en(sd_we), .wr_addr(sd_wa), .wr_data(sd_wd),
      .rd_addr(sd_ra), .rd_data(sd_rd));
   ght_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_gen (
      .clock(clock), .wr_en(gn_we), .wr_addr(gn_wa), .wr_data(gn_wd),
      .rd_addr(gn_ra), .rd_data(gn_rd));
   ght_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd));

   logic [CW-1:0] last_c;
   logic          handle_ok;
   logic          idx_issued;
   logic          accept;
   logic          have_free, have_fresh;
   logic [AW-1:0] fresh_slot;
   logic          add_commit;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ght_pkg::S_IDLE) && !rsp_valid_ff;
   assign last_c     = dense_count_ff - CW'(1);
   assign idx_issued = !idx_big_ff && ({1'b0, idx_ff} < slots_issued_ff);
   // generation memory read is valid in S_DECIDE
   assign handle_ok  = idx_issued && live_ff[idx_ff] && (gn_rd == gen_ff);
   assign have_free  = free_count_ff != '0;
   assign have_fresh = slots_issued_ff < CAP_C;
   assign fresh_slot = slots_issued_ff[AW-1:0];
   // a full table has no free slot and no fresh one: the add writes nothing
   assign add_commit = !fresh_ff || have_fresh;

   // memory address and write control
   always_comb begin
      dn_we = 1'b0; dn_wa = '0; dn_wd = pay_ff; dn_ra = '0;
      sd_we = 1'b0; sd_wa = '0; sd_wd = '0;     sd_ra = idx_ff;
      gn_we = 1'b0; gn_wa = idx_ff; gn_wd = '0; gn_ra = idx_ff;
      fs_we = 1'b0; fs_wa = free_count_ff[AW-1:0]; fs_wd = idx_ff;
      fs_ra = AW'(free_count_ff - CW'(1));
      case (state_ff)
         ght_pkg::S_READ: begin
            // reads of map, generation and free stack top already issued
         end
         ght_pkg::S_DECIDE: begin
            // dense read of the last entry for destroy, of the handle's entry for lookup
            if (func_ff == ght_pkg::FUNC_DESTROY) begin
               dn_ra = last_c[AW-1:0];
            end else begin
               dn_ra = sd_rd;
            end
         end
         ght_pkg::S_MOVE: begin
            dn_we = 1'b1;
            dn_wa = hole_ff;
            dn_wd = dn_rd;
         end
         ght_pkg::S_SCAN: begin
            sd_ra = scan_ff;
         end
         ght_pkg::S_FIX: begin
            sd_we = 1'b1;
            sd_wa = scan_ff;
            sd_wd = hole_ff;
         end
         ght_pkg::S_KILL: begin
            gn_we = 1'b1;
            gn_wd = gen_ff + 32'd1;
            fs_we = free_count_ff < CAP_C;
         end
         ght_pkg::S_POP: begin
            // add commits: payload, mapping, fresh generation
            dn_we = add_commit;
            dn_wa = dense_count_ff[AW-1:0];
            sd_we = add_commit;
            sd_wa = slot_ff;
            sd_wd = dense_count_ff[AW-1:0];
            gn_we = fresh_ff && add_commit;
            gn_wa = slot_ff;
            gn_ra = slot_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ght_pkg::S_IDLE:   if (accept) state_in = ght_pkg::S_READ;
         ght_pkg::S_READ:   state_in = ght_pkg::S_DECIDE;
         ght_pkg::S_DECIDE: begin
            case (func_ff)
               ght_pkg::FUNC_ADD:     state_in = ght_pkg::S_POP;
               ght_pkg::FUNC_DESTROY: state_in = (handle_ok && dense_count_ff != '0)
                                                 ? ght_pkg::S_MOVE : ght_pkg::S_RESP;
               default:               state_in = ght_pkg::S_RESP;
            endcase
         end
         ght_pkg::S_MOVE:   state_in = ght_pkg::S_SCAN;
         ght_pkg::S_SCAN:   state_in = ght_pkg::S_SCHK;
         ght_pkg::S_SCHK: begin
            if (scan_cnt_ff >= slots_issued_ff) state_in = ght_pkg::S_KILL;
            else if (live_ff[scan_ff] && {1'b0, sd_rd} == last_c)
               state_in = ght_pkg::S_FIX;
            else state_in = ght_pkg::S_SCAN;
         end
         ght_pkg::S_FIX:    state_in = ght_pkg::S_KILL;
         ght_pkg::S_KILL:   state_in = ght_pkg::S_RESP;
         ght_pkg::S_POP:    state_in = ght_pkg::S_RESP;
         ght_pkg::S_RESP:   state_in = ght_pkg::S_IDLE;
         default:           state_in = ght_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ght_pkg::S_IDLE;
         free_count_ff   <= '0;
         slots_issued_ff <= '0;
         dense_count_ff  <= '0;
         live_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ght_pkg::S_IDLE: begin
               if (accept) begin
                  func_ff    <= req_func;
                  idx_ff     <= AW'(req_handle_index);
                  idx_big_ff <= {24'd0, req_handle_index} >= 32'(CAPACITY);
                  gen_ff     <= req_handle_generation;
                  pay_ff     <= PAYLOAD_WIDTH'(req_payload_in);
               end
            end
            ght_pkg::S_DECIDE: begin
               rsp_idx_ff <= '0;
               rsp_gen_ff <= '0;
               rsp_pay_ff <= '0;
               hole_ff    <= sd_rd;
               scan_ff    <= '0;
               scan_cnt_ff <= '0;
               case (func_ff)
                  ght_pkg::FUNC_ADD: begin
                     rsp_st_ff <= ght_pkg::ST_OK;
                     if (have_free) begin
                        slot_ff  <= fs_rd;
                        fresh_ff <= 1'b0;
                     end else begin
                        slot_ff  <= fresh_slot;
                        fresh_ff <= 1'b1;
                     end
                  end
                  ght_pkg::FUNC_DESTROY: begin
                     rsp_st_ff <= (handle_ok && dense_count_ff != '0)
                                  ? ght_pkg::ST_OK : ght_pkg::ST_STALE;
                  end
                  ght_pkg::FUNC_LOOKUP: begin
                     rsp_st_ff <= handle_ok ? ght_pkg::ST_OK : ght_pkg::ST_STALE;
                  end
                  default: begin
                     rsp_st_ff <= ght_pkg::ST_OK;
                  end
               endcase
            end
            ght_pkg::S_SCHK: begin
               // hold the index on a match so the fix writes that slot
               if (state_in == ght_pkg::S_SCAN) begin
                  scan_ff     <= scan_ff + AW'(1);
                  scan_cnt_ff <= scan_cnt_ff + CW'(1);
               end
            end
            ght_pkg::S_KILL: begin
               dense_count_ff <= last_c;
               live_ff[idx_ff] <= 1'b0;
               if (free_count_ff < CAP_C) free_count_ff <= free_count_ff + CW'(1);
            end
            ght_pkg::S_POP: begin
               if (add_commit) begin
                  live_ff[slot_ff] <= 1'b1;
                  dense_count_ff   <= dense_count_ff + CW'(1);
                  rsp_idx_ff       <= 8'(slot_ff);
                  if (fresh_ff) begin
                     slots_issued_ff <= slots_issued_ff + CW'(1);
                  end else begin
                     free_count_ff <= free_count_ff - CW'(1);
                  end
               end else begin
                  rsp_st_ff <= ght_pkg::ST_FULL;
               end
            end
            ght_pkg::S_RESP: begin
               rsp_valid_ff <= 1'b1;
               // the generation read for add, issued in S_POP, is valid here
               if (func_ff == ght_pkg::FUNC_ADD && rsp_st_ff == ght_pkg::ST_OK)
                  rsp_gen_ff <= fresh_ff ? 32'd0 : gn_rd;
               if (func_ff == ght_pkg::FUNC_LOOKUP && rsp_st_ff == ght_pkg::ST_OK)
                  rsp_pay_ff <= 32'(dn_rd);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_index      = rsp_idx_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_payload_out    = rsp_pay_ff;
   assign rsp_status         = rsp_st_ff;

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("accept while result pending");
   a_dense_bound: assert property (@(posedge clock) disable iff (reset)
      dense_count_ff <= slots_issued_ff) else $error("dense count exceeds slots");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= slots_issued_ff) else $error("free count exceeds slots");
endmodule

>>> sim/generational_handle_table_tb.sv
// self-checking testbench for the generational handle table
module generational_handle_table_tb;

   localparam int SLOTS = 256;
   localparam logic [1:0] OP_ADD     = ght_pkg::FUNC_ADD;
   localparam logic [1:0] OP_DESTROY = ght_pkg::FUNC_DESTROY;
   localparam logic [1:0] OP_LOOKUP  = ght_pkg::FUNC_LOOKUP;
   localparam logic [1:0] OP_SPARE   = 2'd3;
   localparam logic [1:0] RS_OK      = ght_pkg::ST_OK;
   localparam logic [1:0] RS_STALE   = ght_pkg::ST_STALE;
   localparam logic [1:0] RS_FULL    = ght_pkg::ST_FULL;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [7:0]  req_handle_index;
   logic [31:0] req_handle_generation;
   logic [31:0] req_payload_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_index;
   logic [31:0] rsp_out_generation;
   logic [31:0] rsp_payload_out;
   logic [1:0]  rsp_status;

   typedef struct packed {
      logic [7:0]  index;
      logic [31:0] generation;
      logic [31:0] payload;
      logic [1:0]  status;
   } handle_rsp_type;

   typedef struct {
      logic [1:0]  func;
      logic [7:0]  index;
      logic [31:0] generation;
      logic [31:0] payload;
      bit          known;
      handle_rsp_type answer;
   } table_row_type;

   typedef struct {
      bit          known;
      handle_rsp_type answer;
   } typed_answer_type;

   generational_handle_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_handle_index(req_handle_index),
      .req_handle_generation(req_handle_generation),
      .req_payload_in(req_payload_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_index(rsp_out_index), .rsp_out_generation(rsp_out_generation),
      .rsp_payload_out(rsp_payload_out), .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // shadow copy of the table
   logic [31:0] dense_words [SLOTS];
   logic [8:0]  slot_pos    [SLOTS];
   bit          slot_alive  [SLOTS];
   logic [31:0] slot_gen    [SLOTS];
   logic [7:0]  free_slots  [SLOTS];
   int          free_depth;
   int          issued;
   int          dense_depth;

   handle_rsp_type   pending_rsp [$];
   typed_answer_type typed_answers [$];
   int               fail_count;
   bit               long_hold;

   function automatic bit handle_live(logic [7:0] idx, logic [31:0] gen);
      return (idx < issued) && slot_alive[idx] && (slot_gen[idx] == gen);
   endfunction

   // applies one item to the shadow table and gives its result
   function automatic handle_rsp_type apply_item(logic [1:0] func, logic [7:0] idx,
                                                 logic [31:0] gen, logic [31:0] pay);
      handle_rsp_type r;
      int slot;
      int hole;
      int last;
      r = '0;
      r.status = RS_OK;
      case (func)
         OP_ADD: begin
            slot = -1;
            if (free_depth > 0) begin
               free_depth--;
               slot = free_slots[free_depth];
            end else if (issued < SLOTS) begin
               slot = issued;
               issued++;
               slot_gen[slot] = '0;
            end
            if (slot >= 0 && dense_depth < SLOTS) begin
               dense_words[dense_depth] = pay;
               slot_pos[slot] = dense_depth[8:0];
               slot_alive[slot] = 1'b1;
               dense_depth++;
               r.index = slot[7:0];
               r.generation = slot_gen[slot];
            end else begin
               r.status = RS_FULL;
            end
         end
         OP_DESTROY: begin
            if (!handle_live(idx, gen) || dense_depth == 0) begin
               r.status = RS_STALE;
            end else begin
               hole = slot_pos[idx];
               last = dense_depth - 1;
               dense_words[hole] = dense_words[last];
               dense_depth--;
               // first live slot owning the last dense entry takes the hole
               for (int s = 0; s < issued; s++) begin
                  if (slot_alive[s] && slot_pos[s] == last) begin
                     slot_pos[s] = hole[8:0];
                     break;
                  end
               end
               slot_alive[idx] = 1'b0;
               slot_pos[idx] = '0;
               if (free_depth < SLOTS) begin
                  free_slots[free_depth] = idx;
                  free_depth++;
               end
               slot_gen[idx] = slot_gen[idx] + 32'd1;
            end
         end
         OP_LOOKUP: begin
            if (!handle_live(idx, gen)) r.status = RS_STALE;
            else r.payload = dense_words[slot_pos[idx]];
         end
         default: ;
      endcase
      return r;
   endfunction

   // every accepted item gets its expected result queued
   always @(posedge clock) begin
      typed_answer_type ta;
      handle_rsp_type   p;
      if (!reset && req_valid && req_ready) begin
         p = apply_item(req_func, req_handle_index, req_handle_generation,
                        req_payload_in);
         if (typed_answers.size() > 0) begin
            ta = typed_answers.pop_front();
            if (ta.known) p = ta.answer;
         end
         pending_rsp.insert(pending_rsp.size(), p);
      end
   end

   // results compared field by field with the oldest expectation
   always @(posedge clock) begin
      handle_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_out_index !== e.index) begin
               $error("out_index expected %0d got %0d", e.index, rsp_out_index);
               fail_count++;
            end
            if (rsp_out_generation !== e.generation) begin
               $error("out_generation expected %0h got %0h", e.generation,
                      rsp_out_generation);
               fail_count++;
            end
            if (rsp_payload_out !== e.payload) begin
               $error("payload_out expected %0h got %0h", e.payload, rsp_payload_out);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (!reset) @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (1500) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         g = gap_length();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [1:0] func, logic [7:0] idx, logic [31:0] gen,
                            logic [31:0] pay, bit known, handle_rsp_type answer);
      typed_answer_type ta;
      int g;
      ta.known = known;
      ta.answer = answer;
      typed_answers.insert(typed_answers.size(), ta);
      req_valid <= 1'b1;
      req_func <= func;
      req_handle_index <= idx;
      req_handle_generation <= gen;
      req_payload_in <= pay;
      do @(posedge clock); while (!req_ready);
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // picks a handle: an issued slot with its current generation, sometimes a stale one
   task automatic pick_handle(output logic [7:0] idx, output logic [31:0] gen);
      idx = (issued > 0) ? 8'($urandom_range(0, issued - 1)) : 8'd0;
      gen = slot_gen[idx];
      if ($urandom_range(0, 9) == 0) gen = gen - 32'd1;
   endtask

   table_row_type directed [$];

   initial begin
      handle_rsp_type none;
      logic [7:0]  idx;
      logic [31:0] gen;
      int r;
      bit filling;

      reset = 1'b1;
      req_valid = 1'b0;
      req_func = OP_ADD;
      req_handle_index = '0;
      req_handle_generation = '0;
      req_payload_in = '0;
      fail_count = 0;
      long_hold = 1'b0;
      free_depth = 0;
      issued = 0;
      dense_depth = 0;
      for (int i = 0; i < SLOTS; i++) begin
         dense_words[i] = '0; slot_pos[i] = '0; slot_alive[i] = 1'b0;
         slot_gen[i] = '0; free_slots[i] = '0;
      end
      none = '0;

      // directed rows: typed answers after reset, at the extremes, for errors
      directed = '{
         '{OP_LOOKUP, 8'd0, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_STALE}},
         '{OP_DESTROY, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
           '{8'd0, 32'd0, 32'd0, RS_STALE}},
         '{OP_SPARE, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
           '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_ADD, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
           '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd0, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'hFFFFFFFF, RS_OK}},
         '{OP_LOOKUP, 8'd0, 32'd1, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_STALE}},
         '{OP_ADD, 8'd0, 32'd0, 32'd0, 1, '{8'd1, 32'd0, 32'd0, RS_OK}},
         '{OP_ADD, 8'd0, 32'd0, 32'h5A5A5A5A, 1, '{8'd2, 32'd0, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd1, 32'd0, 32'hFFFFFFFF, 1, '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd3, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_STALE}},
         // swap with last entry and retarget
         '{OP_DESTROY, 8'd0, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd2, 32'd0, 32'd0, 0, none},
         '{OP_LOOKUP, 8'd0, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_STALE}},
         '{OP_DESTROY, 8'd0, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_STALE}},
         // freed slot comes back with a bumped generation
         '{OP_ADD, 8'd0, 32'd0, 32'h12345678, 1, '{8'd0, 32'd1, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd0, 32'd1, 32'd0, 0, none},
         '{OP_DESTROY, 8'd2, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_DESTROY, 8'd1, 32'd0, 32'd0, 1, '{8'd0, 32'd0, 32'd0, RS_OK}},
         '{OP_ADD, 8'd0, 32'd0, 32'd7, 1, '{8'd1, 32'd1, 32'd0, RS_OK}},
         '{OP_ADD, 8'd0, 32'd0, 32'd8, 1, '{8'd2, 32'd1, 32'd0, RS_OK}},
         '{OP_LOOKUP, 8'd0, 32'd1, 32'd0, 0, none}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_item(directed[i].func, directed[i].index, directed[i].generation,
                   directed[i].payload, directed[i].known, directed[i].answer);

      // random part: fill and drain phases so the full case is reached
      filling = 1'b1;
      for (int n = 0; n < 1500; n++) begin
         if (n % 250 == 0 && n > 0) filling = !filling;
         if (n == 300) long_hold = 1'b1;
         if (n == 700) begin
            // sender waits until every result is back
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_rsp.size() > 0 || typed_answers.size() > 0)
               @(posedge clock);
         end
         r = $urandom_range(0, 99);
         pick_handle(idx, gen);
         if (r < 8) begin
            // noise: any field value, unused code included
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      $urandom(), $urandom(), 0, none);
         end else if (r < (filling ? 75 : 35)) begin
            send_item(OP_ADD, 8'($urandom_range(0, 255)), $urandom(), $urandom(),
                      0, none);
         end else if (r < (filling ? 85 : 75)) begin
            send_item(OP_DESTROY, idx, gen, $urandom(), 0, none);
         end else begin
            send_item(OP_LOOKUP, idx, gen, $urandom(), 0, none);
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (pending_rsp.size() > 0) begin
         $error("expected result items left over");
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #100000000;
      $display("FAILURE");
      $finish;
   end

endmodule
